// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/c65alu_pkg.sv =====
// Shared types and constants for the 6502 register/ALU execute block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package c65alu_pkg;

    // Operation selector codes
    localparam logic [5:0] MODE_LDA = 6'd0;
    localparam logic [5:0] MODE_LDX = 6'd1;
    localparam logic [5:0] MODE_LDY = 6'd2;
    localparam logic [5:0] MODE_STA = 6'd3;
    localparam logic [5:0] MODE_STX = 6'd4;
    localparam logic [5:0] MODE_STY = 6'd5;
    localparam logic [5:0] MODE_TAX = 6'd6;
    localparam logic [5:0] MODE_TAY = 6'd7;
    localparam logic [5:0] MODE_TXA = 6'd8;
    localparam logic [5:0] MODE_TYA = 6'd9;
    localparam logic [5:0] MODE_INX = 6'd10;
    localparam logic [5:0] MODE_INY = 6'd11;
    localparam logic [5:0] MODE_DEX = 6'd12;
    localparam logic [5:0] MODE_DEY = 6'd13;
    localparam logic [5:0] MODE_ADC = 6'd14;
    localparam logic [5:0] MODE_SBC = 6'd15;
    localparam logic [5:0] MODE_AND = 6'd16;
    localparam logic [5:0] MODE_EOR = 6'd17;
    localparam logic [5:0] MODE_ORA = 6'd18;
    localparam logic [5:0] MODE_CMP = 6'd19;
    localparam logic [5:0] MODE_CPX = 6'd20;
    localparam logic [5:0] MODE_CPY = 6'd21;
    localparam logic [5:0] MODE_BIT = 6'd22;
    localparam logic [5:0] MODE_ASL = 6'd23;
    localparam logic [5:0] MODE_LSR = 6'd24;
    localparam logic [5:0] MODE_ROL = 6'd25;
    localparam logic [5:0] MODE_ROR = 6'd26;
    localparam logic [5:0] MODE_INC = 6'd27;
    localparam logic [5:0] MODE_DEC = 6'd28;
    localparam logic [5:0] MODE_SEC = 6'd29;
    localparam logic [5:0] MODE_SEI = 6'd30;
    localparam logic [5:0] MODE_SED = 6'd31;
    localparam logic [5:0] MODE_CLC = 6'd32;
    localparam logic [5:0] MODE_CLI = 6'd33;
    localparam logic [5:0] MODE_CLV = 6'd34;
    localparam logic [5:0] MODE_CLD = 6'd35;
    localparam logic [5:0] MODE_NOP = 6'd36;
    localparam logic [5:0] MODE_TSX = 6'd37;
    localparam logic [5:0] MODE_TXS = 6'd38;

    // Status bit positions (NV-BDIZC)
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Architectural register set
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
        logic [7:0] sp;
    } arch_t;

    localparam arch_t ARCH_RESET = '{a: 8'h00, x: 8'h00, y: 8'h00, p: 8'h20, sp: 8'h00};

endpackage

`default_nettype wire

// ===== hdl/cpu_6502_alu_register_execute_top.sv =====
// Top level of the 6502 register/ALU execute block: input register, execute, result register.
// Depends on c65alu_pkg, c65alu_exec, c65alu_regs and assert_macros.svh.
//
//  Channel  Handshake                   Word carried
//  -------  --------------------------  ---------------------------------------------------
//  item     item_valid / item_stall     mode, operand, on_accumulator
//  result   result_valid / result_stall store_valid, store_value, acc_out, x_out, y_out,
//                                       flags_out, sp_out
//
// Each accepted word sits in the input register while the execute logic works on it and
// lands in the result register once that register is free or being emptied.
// A new word is accepted every cycle while item_stall is low; the throughput of one word per
// cycle is set by the combinational 8-bit adder/logic path.
// Reset (rst_n low) clears both valid bits and loads A=X=Y=SP=0, P=0x20.
// When result_stall holds, the result register holds and one more word waits in the input
// register; item_stall rises only once that register is also full.
`timescale 1ns / 1ps
`default_nettype none

module cpu_6502_alu_register_execute_top (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [5:0] mode,
    input  wire logic [7:0] operand,
    input  wire logic       on_accumulator,

    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            store_valid,
    output logic [7:0]      store_value,
    output logic [7:0]      acc_out,
    output logic [7:0]      x_out,
    output logic [7:0]      y_out,
    output logic [7:0]      flags_out,
    output logic [7:0]      sp_out
);

    // Input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [5:0] mode_reg;
    logic [7:0] operand_reg;
    logic       on_acc_reg;

    // Result register (store fields; register fields come straight from the register file)
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       store_valid_reg;
    logic [7:0] store_value_reg;

    // Execute path
    c65alu_pkg::arch_t arch_cur;
    c65alu_pkg::arch_t arch_next;
    logic              exec_store_valid;
    logic [7:0]        exec_store_value;
    logic              exec_fire;
    logic              item_take;

    // Execute when a word waits and the result register is free or being emptied
    assign exec_fire  = in_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !exec_fire;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (exec_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (exec_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: load the input word on accept, the store fields on execute
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            mode_reg    <= mode;
            operand_reg <= operand;
            on_acc_reg  <= on_accumulator;
        end
        if (exec_fire)
        begin
            store_valid_reg <= exec_store_valid;
            store_value_reg <= exec_store_value;
        end
    end

    c65alu_exec u_exec (
        .mode           (mode_reg),
        .operand        (operand_reg),
        .on_accumulator (on_acc_reg),
        .arch_cur       (arch_cur),
        .arch_next      (arch_next),
        .store_valid    (exec_store_valid),
        .store_value    (exec_store_value)
    );

    // The register file advances exactly when a result is loaded, so it always matches
    // the word sitting in the result register and doubles as its register fields.
    c65alu_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (exec_fire),
        .arch_next (arch_next),
        .arch_cur  (arch_cur)
    );

    assign result_valid = res_valid_reg;
    assign store_valid  = store_valid_reg;
    assign store_value  = store_value_reg;
    assign acc_out      = arch_cur.a;
    assign x_out        = arch_cur.x;
    assign y_out        = arch_cur.y;
    assign flags_out    = arch_cur.p;
    assign sp_out       = arch_cur.sp;

`include "assert_macros.svh"

    `ASSERT_NOW(a_no_store_zero, result_valid && !store_valid, store_value == 8'h00,
                "store_value nonzero without store")
    `ASSERT_NEXT(a_regs_hold, !exec_fire, $stable(arch_cur),
                 "registers changed without an executed word")
    `ASSERT_NEXT(a_flags_fixed, exec_fire,
                 flags_out[5] && (flags_out[4] == $past(flags_out[4])),
                 "unused or B flag disturbed")
    `ASSERT_NOW(a_stall_full, item_stall, in_valid_reg && res_valid_reg,
                "input stalled with free space")

endmodule

`default_nettype wire

// ===== hdl/c65alu_exec.sv =====
// Single-pass execute logic: next register set and write-back byte for one op.
// Depends on c65alu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c65alu_exec (
    input  wire logic [5:0]          mode,
    input  wire logic [7:0]          operand,
    input  wire logic                on_accumulator,
    input  wire c65alu_pkg::arch_t   arch_cur,
    output c65alu_pkg::arch_t        arch_next,
    output logic                     store_valid,
    output logic [7:0]               store_value
);

    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] cmp_src;
    logic [8:0] cmp_diff;
    logic [7:0] shift_src;
    logic [7:0] shift_res;
    logic       shift_carry;
    logic       nz_upd;
    logic [7:0] nz_val;

    // Adder, shared by ADC and SBC (SBC adds the inverted operand)
    assign addend = (mode == c65alu_pkg::MODE_SBC) ? ~operand : operand;
    assign sum    = {1'b0, arch_cur.a} + {1'b0, addend}
                  + {8'b0, arch_cur.p[c65alu_pkg::FLAG_C]};

    // Compare subtractor; bit 8 set means borrow
    always_comb
    begin
        unique case (mode)
            c65alu_pkg::MODE_CPX: cmp_src = arch_cur.x;
            c65alu_pkg::MODE_CPY: cmp_src = arch_cur.y;
            default:              cmp_src = arch_cur.a;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_src} - {1'b0, operand};

    // Shifter
    assign shift_src = on_accumulator ? arch_cur.a : operand;
    always_comb
    begin
        case (mode)
            c65alu_pkg::MODE_ASL:
            begin
                shift_res   = {shift_src[6:0], 1'b0};
                shift_carry = shift_src[7];
            end
            c65alu_pkg::MODE_LSR:
            begin
                shift_res   = {1'b0, shift_src[7:1]};
                shift_carry = shift_src[0];
            end
            c65alu_pkg::MODE_ROL:
            begin
                shift_res   = {shift_src[6:0], arch_cur.p[c65alu_pkg::FLAG_C]};
                shift_carry = shift_src[7];
            end
            default:
            begin
                shift_res   = {arch_cur.p[c65alu_pkg::FLAG_C], shift_src[7:1]};
                shift_carry = shift_src[0];
            end
        endcase
    end

    always_comb
    begin
        arch_next   = arch_cur;
        store_valid = 1'b0;
        store_value = 8'h00;
        nz_upd      = 1'b0;
        nz_val      = 8'h00;

        unique case (mode) inside
            c65alu_pkg::MODE_LDA:
            begin
                arch_next.a = operand; nz_upd = 1'b1; nz_val = operand;
            end
            c65alu_pkg::MODE_LDX:
            begin
                arch_next.x = operand; nz_upd = 1'b1; nz_val = operand;
            end
            c65alu_pkg::MODE_LDY:
            begin
                arch_next.y = operand; nz_upd = 1'b1; nz_val = operand;
            end
            c65alu_pkg::MODE_STA:
            begin
                store_valid = 1'b1; store_value = arch_cur.a;
            end
            c65alu_pkg::MODE_STX:
            begin
                store_valid = 1'b1; store_value = arch_cur.x;
            end
            c65alu_pkg::MODE_STY:
            begin
                store_valid = 1'b1; store_value = arch_cur.y;
            end
            c65alu_pkg::MODE_TAX:
            begin
                arch_next.x = arch_cur.a; nz_upd = 1'b1; nz_val = arch_cur.a;
            end
            c65alu_pkg::MODE_TAY:
            begin
                arch_next.y = arch_cur.a; nz_upd = 1'b1; nz_val = arch_cur.a;
            end
            c65alu_pkg::MODE_TXA:
            begin
                arch_next.a = arch_cur.x; nz_upd = 1'b1; nz_val = arch_cur.x;
            end
            c65alu_pkg::MODE_TYA:
            begin
                arch_next.a = arch_cur.y; nz_upd = 1'b1; nz_val = arch_cur.y;
            end
            c65alu_pkg::MODE_INX:
            begin
                arch_next.x = arch_cur.x + 8'd1; nz_upd = 1'b1; nz_val = arch_next.x;
            end
            c65alu_pkg::MODE_INY:
            begin
                arch_next.y = arch_cur.y + 8'd1; nz_upd = 1'b1; nz_val = arch_next.y;
            end
            c65alu_pkg::MODE_DEX:
            begin
                arch_next.x = arch_cur.x - 8'd1; nz_upd = 1'b1; nz_val = arch_next.x;
            end
            c65alu_pkg::MODE_DEY:
            begin
                arch_next.y = arch_cur.y - 8'd1; nz_upd = 1'b1; nz_val = arch_next.y;
            end
            c65alu_pkg::MODE_ADC, c65alu_pkg::MODE_SBC:
            begin
                arch_next.a = sum[7:0];
                arch_next.p[c65alu_pkg::FLAG_V] =
                    ~(arch_cur.a[7] ^ addend[7]) & (arch_cur.a[7] ^ sum[7]);
                arch_next.p[c65alu_pkg::FLAG_C] = sum[8];
                nz_upd = 1'b1;
                nz_val = sum[7:0];
            end
            c65alu_pkg::MODE_AND:
            begin
                arch_next.a = arch_cur.a & operand; nz_upd = 1'b1; nz_val = arch_next.a;
            end
            c65alu_pkg::MODE_EOR:
            begin
                arch_next.a = arch_cur.a ^ operand; nz_upd = 1'b1; nz_val = arch_next.a;
            end
            c65alu_pkg::MODE_ORA:
            begin
                arch_next.a = arch_cur.a | operand; nz_upd = 1'b1; nz_val = arch_next.a;
            end
            c65alu_pkg::MODE_CMP, c65alu_pkg::MODE_CPX, c65alu_pkg::MODE_CPY:
            begin
                arch_next.p[c65alu_pkg::FLAG_C] = ~cmp_diff[8];
                nz_upd = 1'b1;
                nz_val = cmp_diff[7:0];
            end
            c65alu_pkg::MODE_BIT:
            begin
                arch_next.p[c65alu_pkg::FLAG_Z] = ((arch_cur.a & operand) == 8'h00);
                arch_next.p[c65alu_pkg::FLAG_N] = operand[7];
                arch_next.p[c65alu_pkg::FLAG_V] = operand[6];
            end
            c65alu_pkg::MODE_ASL, c65alu_pkg::MODE_LSR,
            c65alu_pkg::MODE_ROL, c65alu_pkg::MODE_ROR:
            begin
                arch_next.p[c65alu_pkg::FLAG_C] = shift_carry;
                nz_upd = 1'b1;
                nz_val = shift_res;
                if (on_accumulator)
                begin
                    arch_next.a = shift_res;
                end
                else
                begin
                    store_valid = 1'b1;
                    store_value = shift_res;
                end
            end
            c65alu_pkg::MODE_INC:
            begin
                store_valid = 1'b1;
                store_value = operand + 8'd1;
                nz_upd      = 1'b1;
                nz_val      = store_value;
            end
            c65alu_pkg::MODE_DEC:
            begin
                store_valid = 1'b1;
                store_value = operand - 8'd1;
                nz_upd      = 1'b1;
                nz_val      = store_value;
            end
            c65alu_pkg::MODE_SEC: arch_next.p[c65alu_pkg::FLAG_C] = 1'b1;
            c65alu_pkg::MODE_SEI: arch_next.p[c65alu_pkg::FLAG_I] = 1'b1;
            c65alu_pkg::MODE_SED: arch_next.p[c65alu_pkg::FLAG_D] = 1'b1;
            c65alu_pkg::MODE_CLC: arch_next.p[c65alu_pkg::FLAG_C] = 1'b0;
            c65alu_pkg::MODE_CLI: arch_next.p[c65alu_pkg::FLAG_I] = 1'b0;
            c65alu_pkg::MODE_CLV: arch_next.p[c65alu_pkg::FLAG_V] = 1'b0;
            c65alu_pkg::MODE_CLD: arch_next.p[c65alu_pkg::FLAG_D] = 1'b0;
            c65alu_pkg::MODE_TSX:
            begin
                arch_next.x = arch_cur.sp; nz_upd = 1'b1; nz_val = arch_cur.sp;
            end
            c65alu_pkg::MODE_TXS: arch_next.sp = arch_cur.x;
            default: ;  // NOP and unused selectors
        endcase

        if (nz_upd)
        begin
            arch_next.p[c65alu_pkg::FLAG_Z] = (nz_val == 8'h00);
            arch_next.p[c65alu_pkg::FLAG_N] = nz_val[7];
        end
        arch_next.p[c65alu_pkg::FLAG_U] = 1'b1;
    end

endmodule

`default_nettype wire

// ===== hdl/c65alu_regs.sv =====
// Architectural register file: A, X, Y, P and SP, loaded once per executed op.
// Depends on c65alu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c65alu_regs (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire c65alu_pkg::arch_t   arch_next,
    output c65alu_pkg::arch_t        arch_cur
);

    c65alu_pkg::arch_t arch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arch_reg <= c65alu_pkg::ARCH_RESET;
        end
        else if (load)
        begin
            arch_reg <= arch_next;
        end
    end

    assign arch_cur = arch_reg;

endmodule

`default_nettype wire
